[src/sphere_set_separation_distance_unit_macros.svh]
// assertion macros shared by the sphere separation unit
`ifndef SPHERE_SET_SEPARATION_DISTANCE_UNIT_MACROS_SVH
`define SPHERE_SET_SEPARATION_DISTANCE_UNIT_MACROS_SVH
`ifndef NO_ASSERTIONS
// property checked on every rising clock edge outside reset
`define SSDU_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);
// condition in one cycle implies outcome in the next
`define SSDU_ASSERT_NEXT(lbl, pre, post, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) pre |=> post) else $error(msg);
`else
`define SSDU_ASSERT(lbl, prop, msg)
`define SSDU_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

[src/ssdu_pkg.sv]
// shared constants and types of the sphere separation unit
`timescale 1ns / 1ps
package ssdu_pkg;
   localparam int COORD_WIDTH = 32;
   localparam int QUEUE_DEPTH = 2;

   typedef struct packed {
      logic last_pair;
      logic want_points;
   } item_flags_type;

   typedef enum logic [1:0] {F_IDLE, F_SQUARE, F_PUSH} front_state_type;

   typedef enum logic [2:0] {
      B_IDLE, B_SQRT, B_UPDATE, B_MUL, B_DIV, B_APPLY, B_EMIT
   } back_state_type;

   // width of one queue entry: flags, squared distance, two spheres
   function automatic int queue_width(input int cw);
      return 2 + (2 * cw + 4) + 6 * cw + 2 * (cw - 1);
   endfunction
endpackage

[src/ssdu_if.sv]
// request and response channel interfaces
`timescale 1ns / 1ps
interface ssdu_req_if #(parameter int CW = ssdu_pkg::COORD_WIDTH) ();
   logic valid;
   logic ready;
   logic signed [CW-1:0] a_center_x;
   logic signed [CW-1:0] a_center_y;
   logic signed [CW-1:0] a_center_z;
   logic [CW-2:0] a_radius;
   logic signed [CW-1:0] b_center_x;
   logic signed [CW-1:0] b_center_y;
   logic signed [CW-1:0] b_center_z;
   logic [CW-2:0] b_radius;
   logic last_pair;
   logic want_points;
   modport source(output valid, a_center_x, a_center_y, a_center_z, a_radius,
                  b_center_x, b_center_y, b_center_z, b_radius, last_pair,
                  want_points, input ready);
   modport sink(input valid, a_center_x, a_center_y, a_center_z, a_radius,
                b_center_x, b_center_y, b_center_z, b_radius, last_pair,
                want_points, output ready);
endinterface

interface ssdu_rsp_if #(parameter int CW = ssdu_pkg::COORD_WIDTH) ();
   logic valid;
   logic ready;
   logic [CW:0] separation;
   logic points_valid;
   logic signed [CW-1:0] near_a_x;
   logic signed [CW-1:0] near_a_y;
   logic signed [CW-1:0] near_a_z;
   logic signed [CW-1:0] near_b_x;
   logic signed [CW-1:0] near_b_y;
   logic signed [CW-1:0] near_b_z;
   modport source(output valid, separation, points_valid, near_a_x, near_a_y,
                  near_a_z, near_b_x, near_b_y, near_b_z, input ready);
   modport sink(input valid, separation, points_valid, near_a_x, near_a_y,
                near_a_z, near_b_x, near_b_y, near_b_z, output ready);
endinterface

[src/sphere_set_separation_distance_unit.sv]
// top level of the sphere set separation distance unit
//
//   channel  dir  handshake     payload
//   req_if   in   valid/ready   two spheres, last_pair, want_points
//   rsp_if   out  valid/ready   separation, points_valid, six near coordinates
//
// the front end forms the squared distance of each pair, one axis at a time
// the back end handles each pair with a bit-serial square root
// a last pair with points adds bit-serial division for the six near coordinates
// reset is synchronous and clears control state and the running maximum
// a stalled response holds the back end at the next last pair only
`timescale 1ns / 1ps
module sphere_set_separation_distance_unit #(
   parameter int COORD_WIDTH = ssdu_pkg::COORD_WIDTH,
   parameter int QUEUE_DEPTH = ssdu_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   ssdu_req_if.sink req_if,
   ssdu_rsp_if.source rsp_if
);
   import ssdu_pkg::*;

   localparam int QW = queue_width(COORD_WIDTH);

   logic push_valid, push_ready, pop_valid, pop_ready;
   logic [QW-1:0] push_data, pop_data;

   // pair intake and squared distance
   ssdu_front #(.CW(COORD_WIDTH)) u_front (
      .clock(clock), .reset(reset), .req_if(req_if),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data)
   );

   // decoupling queue
   ssdu_queue #(.W(QW), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .push_valid(push_valid), .push_ready(push_ready), .push_data(push_data),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data)
   );

   // root, maximum and points
   ssdu_back #(.CW(COORD_WIDTH)) u_back (
      .clock(clock), .reset(reset),
      .pop_valid(pop_valid), .pop_ready(pop_ready), .pop_data(pop_data),
      .rsp_if(rsp_if)
   );
endmodule

[src/ssdu_front.sv]
// front end: takes a sphere pair and forms the squared center distance
`timescale 1ns / 1ps
module ssdu_front #(
   parameter int CW = ssdu_pkg::COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   ssdu_req_if.sink req_if,
   output logic push_valid,
   input  logic push_ready,
   output logic [ssdu_pkg::queue_width(CW)-1:0] push_data
);
   import ssdu_pkg::*;

   front_state_type state_ff, state_in;
   logic [1:0] cnt_ff;
   logic signed [CW-1:0] ac_ff [3];
   logic signed [CW-1:0] bc_ff [3];
   logic [CW-2:0] ar_ff, br_ff;
   item_flags_type flags_ff;
   logic [2*CW+1:0] sq_ff;
   logic [2*CW+3:0] acc_ff;
   logic signed [CW-1:0] ac_sel, bc_sel;
   logic [CW:0] diff, abs_diff;
   logic accept;

   // axis picked by the step counter
   always_comb begin
      case (cnt_ff)
         2'd0: begin
            ac_sel = ac_ff[0];
            bc_sel = bc_ff[0];
         end
         2'd1: begin
            ac_sel = ac_ff[1];
            bc_sel = bc_ff[1];
         end
         default: begin
            ac_sel = ac_ff[2];
            bc_sel = bc_ff[2];
         end
      endcase
      diff = {ac_sel[CW-1], ac_sel} - {bc_sel[CW-1], bc_sel};
      abs_diff = diff[CW] ? (~diff + 1'b1) : diff;
   end

   // next state
   always_comb begin
      case (state_ff)
         F_IDLE:   state_in = req_if.valid ? F_SQUARE : F_IDLE;
         F_SQUARE: state_in = (cnt_ff == 2'd3) ? F_PUSH : F_SQUARE;
         F_PUSH:   state_in = push_ready ? F_IDLE : F_PUSH;
         default:  state_in = F_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      req_if.ready = (state_ff == F_IDLE);
      push_valid = (state_ff == F_PUSH);
   end

   assign accept = req_if.valid && req_if.ready;
   assign push_data = {flags_ff, acc_ff, ac_ff[0], ac_ff[1], ac_ff[2], ar_ff,
                       bc_ff[0], bc_ff[1], bc_ff[2], br_ff};

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         cnt_ff <= 2'd0;
      end else begin
         state_ff <= state_in;
         if (accept) begin
            cnt_ff <= 2'd0;
         end else if (state_ff == F_SQUARE) begin
            cnt_ff <= cnt_ff + 2'd1;
         end
      end
   end

   // capture the pair, then square and sum one axis per cycle
   always_ff @(posedge clock) begin
      if (accept) begin
         ac_ff[0] <= req_if.a_center_x;
         ac_ff[1] <= req_if.a_center_y;
         ac_ff[2] <= req_if.a_center_z;
         bc_ff[0] <= req_if.b_center_x;
         bc_ff[1] <= req_if.b_center_y;
         bc_ff[2] <= req_if.b_center_z;
         ar_ff <= req_if.a_radius;
         br_ff <= req_if.b_radius;
         flags_ff.last_pair <= req_if.last_pair;
         flags_ff.want_points <= req_if.want_points;
         acc_ff <= '0;
      end else if (state_ff == F_SQUARE) begin
         if (cnt_ff != 2'd3) begin
            sq_ff <= abs_diff * abs_diff;
         end
         if (cnt_ff != 2'd0) begin
            acc_ff <= acc_ff + {2'b00, sq_ff};
         end
      end
   end
endmodule

[src/ssdu_queue.sv]
// short queue between the front and back ends
`timescale 1ns / 1ps
`include "sphere_set_separation_distance_unit_macros.svh"
module ssdu_queue #(
   parameter int W = 8,
   parameter int DEPTH = ssdu_pkg::QUEUE_DEPTH
) (
   input  logic clock,
   input  logic reset,
   input  logic push_valid,
   output logic push_ready,
   input  logic [W-1:0] push_data,
   output logic pop_valid,
   input  logic pop_ready,
   output logic [W-1:0] pop_data
);
   import ssdu_pkg::*;

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [W-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic do_push, do_pop;

   assign push_ready = (cnt_ff != CNT_W'(DEPTH));
   assign pop_valid = (cnt_ff != '0);
   assign pop_data = mem_ff[rd_ptr_ff];
   assign do_push = push_valid && push_ready;
   assign do_pop = pop_valid && pop_ready;

   // pointers and fill count
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            cnt_ff <= cnt_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            cnt_ff <= cnt_ff - 1'b1;
         end
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   `SSDU_ASSERT(a_cnt_max, cnt_ff <= CNT_W'(DEPTH), "queue count above depth")
   `SSDU_ASSERT_NEXT(a_grow, do_push && !do_pop, cnt_ff == $past(cnt_ff) + 1'b1, "queue grow")
   `SSDU_ASSERT_NEXT(a_shrink, do_pop && !do_push, cnt_ff == $past(cnt_ff) - 1'b1, "queue shrink")
endmodule

[src/ssdu_back.sv]
// back end: square root, running maximum and near surface points
`timescale 1ns / 1ps
`include "sphere_set_separation_distance_unit_macros.svh"
module ssdu_back #(
   parameter int CW = ssdu_pkg::COORD_WIDTH
) (
   input  logic clock,
   input  logic reset,
   input  logic pop_valid,
   output logic pop_ready,
   input  logic [ssdu_pkg::queue_width(CW)-1:0] pop_data,
   ssdu_rsp_if.source rsp_if
);
   import ssdu_pkg::*;

   localparam int SUM_W = 2 * CW + 4;
   localparam int REM_W = CW + 5;
   localparam int CNT_W = $clog2(2 * CW + 1);

   back_state_type state_ff, state_in;
   item_flags_type pop_flags, flags_ff;
   logic [SUM_W-1:0] pop_sum;
   logic signed [CW-1:0] pop_ax, pop_ay, pop_az, pop_bx, pop_by, pop_bz;
   logic [CW-2:0] pop_ar, pop_br;

   logic signed [CW-1:0] ac_ff [3];
   logic signed [CW-1:0] bc_ff [3];
   logic [CW-2:0] ar_ff, br_ff;
   logic [SUM_W-1:0] rad_ff;
   logic [REM_W-1:0] rem_ff;
   logic [CW+1:0] root_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [CW:0] best_sep_ff;
   logic best_found_ff;
   logic signed [CW-1:0] best_ac_ff [3];
   logic signed [CW-1:0] best_bc_ff [3];
   logic [CW-2:0] best_ar_ff, best_br_ff;
   logic [CW:0] best_len_ff;

   logic [2:0] job_ff;
   logic [2*CW-1:0] dvd_ff, quo_ff;
   logic [CW:0] drem_ff;
   logic neg_ff;
   logic signed [CW-1:0] near_a_ff [3];
   logic signed [CW-1:0] near_b_ff [3];

   logic rsp_valid_ff;
   logic [CW:0] out_sep_ff;
   logic out_pv_ff;
   logic signed [CW-1:0] out_a_ff [3];
   logic signed [CW-1:0] out_b_ff [3];

   logic [REM_W-1:0] sq_rem, sq_trial;
   logic sq_take;
   logic [CW-1:0] rad_sum;
   logic signed [CW+2:0] sep;
   logic upd;
   logic side_b;
   logic [1:0] axis;
   logic signed [CW:0] vdiff;
   logic [CW:0] vabs;
   logic [CW+1:0] dv_rem;
   logic dv_take;
   logic [CW-1:0] offset;
   logic signed [CW-1:0] base;
   logic signed [CW+1:0] coord;
   logic signed [CW-1:0] coord_sat;
   logic emit_ok;

   assign {pop_flags, pop_sum, pop_ax, pop_ay, pop_az, pop_ar,
           pop_bx, pop_by, pop_bz, pop_br} = pop_data;

   // one root bit per cycle
   always_comb begin
      sq_rem = {rem_ff[REM_W-3:0], rad_ff[SUM_W-1:SUM_W-2]};
      sq_trial = {{(REM_W-CW-4){1'b0}}, root_ff, 2'b01};
      sq_take = (sq_rem >= sq_trial);
   end

   // candidate separation against the running maximum
   always_comb begin
      rad_sum = {1'b0, ar_ff} + {1'b0, br_ff};
      sep = $signed({2'b00, root_ff[CW:0]}) - $signed({3'b000, rad_sum});
      upd = (sep > $signed({2'b00, best_sep_ff}));
   end

   // point job: axis and side
   always_comb begin
      side_b = (job_ff >= 3'd3);
      case (job_ff)
         3'd0, 3'd3: axis = 2'd0;
         3'd1, 3'd4: axis = 2'd1;
         default:    axis = 2'd2;
      endcase
      vdiff = {best_ac_ff[axis][CW-1], best_ac_ff[axis]}
            - {best_bc_ff[axis][CW-1], best_bc_ff[axis]};
      vabs = vdiff[CW] ? (~vdiff + 1'b1) : vdiff;
   end

   // one quotient bit per cycle
   always_comb begin
      dv_rem = {drem_ff, dvd_ff[2*CW-1]};
      dv_take = (dv_rem >= {1'b0, best_len_ff});
   end

   // offset applied to the center, then saturated
   always_comb begin
      offset = (best_len_ff == '0) ? '0 : quo_ff[CW-1:0];
      base = side_b ? best_bc_ff[axis] : best_ac_ff[axis];
      if (neg_ff == side_b) begin
         coord = {{2{base[CW-1]}}, base} - {2'b00, offset};
      end else begin
         coord = {{2{base[CW-1]}}, base} + {2'b00, offset};
      end
      if ((coord[CW+1] == coord[CW]) && (coord[CW] == coord[CW-1])) begin
         coord_sat = coord[CW-1:0];
      end else if (coord[CW+1]) begin
         coord_sat = {1'b1, {(CW-1){1'b0}}};
      end else begin
         coord_sat = {1'b0, {(CW-1){1'b1}}};
      end
   end

   assign emit_ok = !rsp_valid_ff || rsp_if.ready;

   // next state
   always_comb begin
      case (state_ff)
         B_IDLE:   state_in = pop_valid ? B_SQRT : B_IDLE;
         B_SQRT:   state_in = (cnt_ff == CNT_W'(1)) ? B_UPDATE : B_SQRT;
         B_UPDATE: begin
            if (!flags_ff.last_pair) begin
               state_in = B_IDLE;
            end else if (flags_ff.want_points && (best_found_ff || upd)) begin
               state_in = B_MUL;
            end else begin
               state_in = B_EMIT;
            end
         end
         B_MUL:    state_in = B_DIV;
         B_DIV:    state_in = (cnt_ff == CNT_W'(1)) ? B_APPLY : B_DIV;
         B_APPLY:  state_in = (job_ff == 3'd5) ? B_EMIT : B_MUL;
         B_EMIT:   state_in = emit_ok ? B_IDLE : B_EMIT;
         default:  state_in = B_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      pop_ready = (state_ff == B_IDLE);
      rsp_if.valid = rsp_valid_ff;
   end

   assign rsp_if.separation = out_sep_ff;
   assign rsp_if.points_valid = out_pv_ff;
   assign rsp_if.near_a_x = out_a_ff[0];
   assign rsp_if.near_a_y = out_a_ff[1];
   assign rsp_if.near_a_z = out_a_ff[2];
   assign rsp_if.near_b_x = out_b_ff[0];
   assign rsp_if.near_b_y = out_b_ff[1];
   assign rsp_if.near_b_z = out_b_ff[2];

   // control state and running best
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
         best_sep_ff <= '0;
         best_found_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         job_ff <= 3'd0;
      end else begin
         state_ff <= state_in;
         // response valid: set on emit, cleared on transfer
         if ((state_ff == B_EMIT) && emit_ok) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_if.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            B_UPDATE: begin
               if (upd) begin
                  best_sep_ff <= sep[CW:0];
                  best_found_ff <= 1'b1;
               end
               job_ff <= 3'd0;
            end
            B_APPLY: job_ff <= job_ff + 3'd1;
            B_EMIT: begin
               if (emit_ok) begin
                  best_sep_ff <= '0;
                  best_found_ff <= 1'b0;
               end
            end
            default: ;
         endcase
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            if (pop_valid) begin
               ac_ff[0] <= pop_ax;
               ac_ff[1] <= pop_ay;
               ac_ff[2] <= pop_az;
               bc_ff[0] <= pop_bx;
               bc_ff[1] <= pop_by;
               bc_ff[2] <= pop_bz;
               ar_ff <= pop_ar;
               br_ff <= pop_br;
               flags_ff <= pop_flags;
               rad_ff <= pop_sum;
               rem_ff <= '0;
               root_ff <= '0;
               cnt_ff <= CNT_W'(CW + 2);
            end
         end
         B_SQRT: begin
            rad_ff <= {rad_ff[SUM_W-3:0], 2'b00};
            rem_ff <= sq_take ? (sq_rem - sq_trial) : sq_rem;
            root_ff <= {root_ff[CW:0], sq_take};
            cnt_ff <= cnt_ff - 1'b1;
         end
         B_UPDATE: begin
            if (upd) begin
               best_ac_ff <= ac_ff;
               best_bc_ff <= bc_ff;
               best_ar_ff <= ar_ff;
               best_br_ff <= br_ff;
               best_len_ff <= root_ff[CW:0];
            end
         end
         B_MUL: begin
            dvd_ff <= vabs * (side_b ? best_br_ff : best_ar_ff);
            neg_ff <= vdiff[CW];
            drem_ff <= '0;
            quo_ff <= '0;
            cnt_ff <= CNT_W'(2 * CW);
         end
         B_DIV: begin
            dvd_ff <= {dvd_ff[2*CW-2:0], 1'b0};
            drem_ff <= dv_take ? (CW+1)'(dv_rem - {1'b0, best_len_ff})
                               : dv_rem[CW:0];
            quo_ff <= {quo_ff[2*CW-2:0], dv_take};
            cnt_ff <= cnt_ff - 1'b1;
         end
         B_APPLY: begin
            if (side_b) begin
               near_b_ff[axis] <= coord_sat;
            end else begin
               near_a_ff[axis] <= coord_sat;
            end
         end
         B_EMIT: begin
            if (emit_ok) begin
               out_sep_ff <= best_sep_ff;
               out_pv_ff <= flags_ff.want_points && best_found_ff;
               for (int i = 0; i < 3; i++) begin
                  out_a_ff[i] <= (flags_ff.want_points && best_found_ff) ? near_a_ff[i] : '0;
                  out_b_ff[i] <= (flags_ff.want_points && best_found_ff) ? near_b_ff[i] : '0;
               end
            end
         end
         default: ;
      endcase
   end

   `SSDU_ASSERT(a_sep_found, (best_sep_ff != '0) |-> best_found_ff, "best value without pair")
   `SSDU_ASSERT(a_len_nonzero, best_found_ff |-> (best_len_ff != '0), "stored pair has zero length")
   `SSDU_ASSERT(a_div_found, (state_ff == B_DIV) |-> best_found_ff, "points without stored pair")
endmodule
